>>> src/mmc_seq_pkg.sv
`default_nettype none

package mmc_seq_pkg;

    localparam int BLOCK_BYTES = 512;
    // byte counter also counts the init clock bytes (8-bit register)
    localparam int BC_BLK = $clog2(BLOCK_BYTES + 1);
    localparam int BC_W = (BC_BLK > 8) ? BC_BLK : 8;

    localparam logic [1:0] OP_EXCH  = 2'd0;
    localparam logic [1:0] OP_INIT  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_RETRY   = 2'd1;
    localparam logic [1:0] CFG_CLOCKS  = 2'd2;

    localparam logic [7:0] CMD0_CODE  = 8'h40;
    localparam logic [7:0] CMD0_CRC   = 8'h95;
    localparam logic [7:0] CMD1_CODE  = 8'h41;
    localparam logic [7:0] CMD16_CODE = 8'h50;
    localparam logic [7:0] CMD17_CODE = 8'h51;
    localparam logic [7:0] CMD24_CODE = 8'h58;
    localparam logic [7:0] IDLE_BYTE  = 8'hFF;
    localparam logic [7:0] DATA_TOKEN = 8'hFE;
    localparam logic [7:0] R1_IDLE    = 8'h01;
    localparam logic [7:0] R1_READY   = 8'h00;
    localparam logic [3:0] DRESP_MASK = 4'hF;
    localparam logic [3:0] DRESP_OK   = 4'h5;
    localparam logic [2:0] CMD_LEN    = 3'd6;

    typedef enum logic [22:0] {
        PH_IDLE       = 23'h000001,
        PH_INIT_CLK   = 23'h000002,
        PH_CMD0_TX    = 23'h000004,
        PH_CMD0_WAIT  = 23'h000008,
        PH_CMD1_TX    = 23'h000010,
        PH_CMD1_WAIT  = 23'h000020,
        PH_INIT_GAP   = 23'h000040,
        PH_CMD16_TX   = 23'h000080,
        PH_CMD16_WAIT = 23'h000100,
        PH_RD_TX      = 23'h000200,
        PH_RD_WAIT    = 23'h000400,
        PH_TOK_WAIT   = 23'h000800,
        PH_RD_DATA    = 23'h001000,
        PH_RD_CRC1    = 23'h002000,
        PH_RD_CRC2    = 23'h004000,
        PH_RD_TAIL    = 23'h008000,
        PH_WR_TX      = 23'h010000,
        PH_WR_WAIT    = 23'h020000,
        PH_WR_DATA    = 23'h040000,
        PH_WR_CRC1    = 23'h080000,
        PH_WR_CRC2    = 23'h100000,
        PH_WR_POLL    = 23'h200000,
        PH_WR_CHECK   = 23'h400000
    } phase_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] block_number;
        logic [7:0]  miso_byte;
        logic [7:0]  write_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       send_byte;
        logic       select_n;
        logic       want_data;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } result_t;

    // one byte of a six-byte command frame
    function automatic logic [7:0] cmd_byte(phase_t ph, logic [2:0] idx, logic [15:0] blk);
        logic [7:0]  code;
        logic [7:0]  crc;
        logic [31:0] arg;
        code = CMD24_CODE;
        crc  = IDLE_BYTE;
        arg  = 32'(blk) * 32'(BLOCK_BYTES);
        case (ph)
            PH_CMD0_TX:
            begin
                code = CMD0_CODE;
                crc  = CMD0_CRC;
                arg  = '0;
            end
            PH_CMD1_TX:
            begin
                code = CMD1_CODE;
                arg  = '0;
            end
            PH_CMD16_TX:
            begin
                code = CMD16_CODE;
                arg  = 32'(BLOCK_BYTES);
            end
            PH_RD_TX: code = CMD17_CODE;
            default: code = CMD24_CODE;
        endcase
        case (idx)
            3'd0: cmd_byte = code;
            3'd1: cmd_byte = arg[31:24];
            3'd2: cmd_byte = arg[23:16];
            3'd3: cmd_byte = arg[15:8];
            3'd4: cmd_byte = arg[7:0];
            default: cmd_byte = crc;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> src/mmc_spi_block_sequencer_top.sv
// Each result passes through the input register and then the result register after its item transfer.
// Throughput: one item per cycle when not stalled; the sequencer state advances once per item.
// Result stall backs up into item_stall only when both registers are full.
// Reset: asynchronous, active low; phase idle, counters cleared, card released,
// registers at response_timeout 65535, init_retry_limit 255, init_clock_bytes 10.
`default_nettype none

module mmc_spi_block_sequencer_top
    import mmc_seq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire item_t       item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    logic [15:0]     timeout_reg;
    logic [7:0]      retry_lim_reg;
    logic [7:0]      clk_bytes_reg;

    logic            in_valid_reg;
    item_t           in_reg;
    logic            out_valid_reg;
    result_t         out_reg;

    phase_t          ph_reg, ph_next;
    logic [BC_W-1:0] bc_reg, bc_next;
    logic [15:0]     wc_reg, wc_next;
    logic [7:0]      rc_reg, rc_next;
    logic [15:0]     blk_reg, blk_next;
    logic            sel_reg, sel_next;

    result_t         res_c;
    logic            adv;
    logic [15:0]     wc_inc;
    logic [7:0]      rc_inc;
    logic [BC_W-1:0] bc_inc;
    logic [7:0]      expect_byte;
    logic            hit, tmo;

    assign adv          = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall   = in_valid_reg && !adv;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= 16'hFFFF;
            retry_lim_reg <= 8'd255;
            clk_bytes_reg <= 8'd10;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg   <= cfg_wdata;
                CFG_RETRY:   retry_lim_reg <= cfg_wdata[7:0];
                CFG_CLOCKS:  clk_bytes_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ph_reg        <= PH_IDLE;
            bc_reg        <= '0;
            wc_reg        <= '0;
            rc_reg        <= '0;
            blk_reg       <= '0;
            sel_reg       <= 1'b1;
        end
        else
        begin
            if (!item_stall)
                in_valid_reg <= item_valid;
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                ph_reg        <= ph_next;
                bc_reg        <= bc_next;
                wc_reg        <= wc_next;
                rc_reg        <= rc_next;
                blk_reg       <= blk_next;
                sel_reg       <= sel_next;
            end
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_reg <= item;
        if (adv)
            out_reg <= res_c;
    end

    // response poll shared by all wait phases
    always_comb
    begin
        case (ph_reg)
            PH_CMD0_WAIT: expect_byte = R1_IDLE;
            PH_TOK_WAIT:  expect_byte = DATA_TOKEN;
            default:      expect_byte = R1_READY;
        endcase
        wc_inc = (wc_reg != 16'hFFFF) ? wc_reg + 16'd1 : wc_reg;
        rc_inc = (rc_reg != 8'hFF) ? rc_reg + 8'd1 : rc_reg;
        bc_inc = bc_reg + BC_W'(1);
        hit    = (in_reg.miso_byte == expect_byte);
        tmo    = (wc_inc >= timeout_reg);
    end

    always_comb
    begin
        ph_next  = ph_reg;
        bc_next  = bc_reg;
        wc_next  = wc_reg;
        rc_next  = rc_reg;
        blk_next = blk_reg;
        sel_next = sel_reg;
        res_c    = '0;

        if (ph_reg == PH_IDLE)
        begin
            case (in_reg.op)
                OP_INIT:
                begin
                    sel_next  = 1'b1;
                    rc_next   = '0;
                    bc_next   = BC_W'(1);
                    ph_next   = PH_INIT_CLK;
                    res_c.mosi_byte = IDLE_BYTE;
                    res_c.send_byte = 1'b1;
                end
                OP_READ, OP_WRITE:
                begin
                    blk_next = in_reg.block_number;
                    sel_next = 1'b0;
                    ph_next  = (in_reg.op == OP_READ) ? PH_RD_TX : PH_WR_TX;
                    bc_next  = BC_W'(1);
                    res_c.mosi_byte = cmd_byte(ph_next, 3'd0, in_reg.block_number);
                    res_c.send_byte = 1'b1;
                end
                default: ;
            endcase
        end
        else if (in_reg.op == OP_EXCH)
        begin
            res_c.mosi_byte = IDLE_BYTE;
            res_c.send_byte = 1'b1;
            case (ph_reg)
                PH_INIT_CLK:
                begin
                    if (bc_reg < BC_W'(clk_bytes_reg))
                        bc_next = bc_inc;
                    else
                    begin
                        sel_next = 1'b0;
                        ph_next  = PH_CMD0_TX;
                        bc_next  = BC_W'(1);
                        res_c.mosi_byte = CMD0_CODE;
                    end
                end
                PH_CMD0_TX, PH_CMD1_TX, PH_CMD16_TX, PH_RD_TX, PH_WR_TX:
                begin
                    if (bc_reg < BC_W'(CMD_LEN))
                    begin
                        res_c.mosi_byte = cmd_byte(ph_reg, bc_reg[2:0], blk_reg);
                        bc_next = bc_inc;
                    end
                    else
                    begin
                        wc_next = '0;
                        case (ph_reg)
                            PH_CMD0_TX:  ph_next = PH_CMD0_WAIT;
                            PH_CMD1_TX:  ph_next = PH_CMD1_WAIT;
                            PH_CMD16_TX: ph_next = PH_CMD16_WAIT;
                            PH_RD_TX:    ph_next = PH_RD_WAIT;
                            default:     ph_next = PH_WR_WAIT;
                        endcase
                    end
                end
                PH_CMD0_WAIT, PH_CMD16_WAIT, PH_RD_WAIT, PH_TOK_WAIT, PH_WR_WAIT:
                begin
                    wc_next = wc_inc;
                    if (hit)
                    begin
                        case (ph_reg)
                            PH_CMD0_WAIT:
                            begin
                                ph_next = PH_CMD1_TX;
                                bc_next = BC_W'(1);
                                res_c.mosi_byte = CMD1_CODE;
                            end
                            PH_CMD16_WAIT:
                            begin
                                res_c.send_byte = 1'b0;
                                res_c.mosi_byte = '0;
                                res_c.done_res  = 1'b1;
                                res_c.status    = ST_OK;
                                sel_next = 1'b1;
                                ph_next  = PH_IDLE;
                            end
                            PH_RD_WAIT:
                            begin
                                wc_next = '0;
                                ph_next = PH_TOK_WAIT;
                            end
                            PH_TOK_WAIT:
                            begin
                                bc_next = '0;
                                ph_next = PH_RD_DATA;
                            end
                            default:
                            begin
                                bc_next = '0;
                                ph_next = PH_WR_DATA;
                                res_c.want_data = 1'b1;
                                res_c.mosi_byte = DATA_TOKEN;
                            end
                        endcase
                    end
                    else if (tmo)
                    begin
                        res_c.send_byte = 1'b0;
                        res_c.mosi_byte = '0;
                        res_c.done_res  = 1'b1;
                        res_c.status    = ST_TIMEOUT;
                        sel_next = 1'b1;
                        ph_next  = PH_IDLE;
                    end
                end
                PH_CMD1_WAIT:
                begin
                    wc_next = wc_inc;
                    if (hit)
                    begin
                        sel_next = 1'b1;
                        ph_next  = PH_INIT_GAP;
                    end
                    else if (tmo || in_reg.miso_byte != IDLE_BYTE)
                    begin
                        // failed attempt: retry CMD1 or give up
                        rc_next = rc_inc;
                        if (rc_inc >= retry_lim_reg)
                        begin
                            res_c.send_byte = 1'b0;
                            res_c.mosi_byte = '0;
                            res_c.done_res  = 1'b1;
                            res_c.status    = ST_TIMEOUT;
                            sel_next = 1'b1;
                            ph_next  = PH_IDLE;
                        end
                        else
                        begin
                            ph_next = PH_CMD1_TX;
                            bc_next = BC_W'(1);
                            res_c.mosi_byte = CMD1_CODE;
                        end
                    end
                end
                PH_INIT_GAP:
                begin
                    sel_next = 1'b0;
                    ph_next  = PH_CMD16_TX;
                    bc_next  = BC_W'(1);
                    res_c.mosi_byte = CMD16_CODE;
                end
                PH_RD_DATA:
                begin
                    res_c.read_valid = 1'b1;
                    res_c.read_byte  = in_reg.miso_byte;
                    bc_next = bc_inc;
                    if (bc_inc >= BC_W'(BLOCK_BYTES))
                        ph_next = PH_RD_CRC1;
                end
                PH_RD_CRC1: ph_next = PH_RD_CRC2;
                PH_RD_CRC2:
                begin
                    sel_next = 1'b1;
                    ph_next  = PH_RD_TAIL;
                end
                PH_WR_DATA:
                begin
                    res_c.mosi_byte = in_reg.write_byte;
                    bc_next = bc_inc;
                    if (bc_inc >= BC_W'(BLOCK_BYTES))
                        ph_next = PH_WR_CRC1;
                    else
                        res_c.want_data = 1'b1;
                end
                PH_WR_CRC1: ph_next = PH_WR_CRC2;
                PH_WR_CRC2: ph_next = PH_WR_POLL;
                PH_WR_POLL: ph_next = PH_WR_CHECK;
                PH_WR_CHECK:
                begin
                    res_c.send_byte = 1'b0;
                    res_c.mosi_byte = '0;
                    res_c.done_res  = 1'b1;
                    res_c.status    = ((in_reg.miso_byte[3:0] & DRESP_MASK) == DRESP_OK)
                                      ? ST_OK : ST_REJECT;
                    sel_next = 1'b1;
                    ph_next  = PH_IDLE;
                end
                default:
                begin
                    // read tail and any stray code end the sequence cleanly
                    res_c.send_byte = 1'b0;
                    res_c.mosi_byte = '0;
                    res_c.done_res  = 1'b1;
                    res_c.status    = ST_OK;
                    sel_next = 1'b1;
                    ph_next  = PH_IDLE;
                end
            endcase
        end

        res_c.select_n = sel_next;
        res_c.busy_res = (ph_next != PH_IDLE);
    end

endmodule

`default_nettype wire

>>> src/mmc_seq_checker.sv
`default_nettype none

module mmc_seq_checker
    import mmc_seq_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // a stalled result transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // a finishing item leaves the sequencer idle with the card released
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.done_res |-> !result.busy_res && result.select_n)
        else $error("done with busy or selected card");

    // error status only on the finishing item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |-> result.done_res)
        else $error("status without done");

    // read data and write requests only inside a running sequence with a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.read_valid || result.want_data)
            |-> result.busy_res && result.send_byte && !result.select_n)
        else $error("data outside of a transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.send_byte |-> result.mosi_byte == 8'h00)
        else $error("mosi byte without transfer");

endmodule

bind mmc_spi_block_sequencer_top mmc_seq_checker u_mmc_seq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import mmc_seq_pkg::*;

    localparam int LIMIT = 2000000;

    typedef struct packed {
        phase_t      ph;
        logic [9:0]  bc;
        logic [15:0] wc;
        logic [7:0]  retry;
        logic [15:0] blk;
        logic        sel;
    } host_state_t;

    localparam host_state_t HOST_RESET = '{PH_IDLE, 10'd0, 16'd0, 8'd0, 16'd0, 1'b1};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item_in = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result_out;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_TIMEOUT;
    logic [15:0] cfg_wdata = 16'h0000;

    // register copies seen by the prediction
    logic [15:0] poll_limit = 16'hFFFF;
    logic [7:0]  cmd1_tries = 8'hFF;
    logic [7:0]  wake_bytes = 8'd10;

    host_state_t dut_s;
    host_state_t gen_s;
    item_t       item_backlog[$];
    result_t     predicted_out[$];
    int          errors = 0;
    int          real_items = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    bit          reject_wr = 1'b0;

    mmc_spi_block_sequencer_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // byte idx of the six-byte frame sent in command phase ph
    function automatic logic [7:0] frame_byte(phase_t ph, logic [9:0] idx, logic [15:0] blk);
        logic [31:0] addr;
        logic [47:0] frame;
        int          k;
        addr = 32'(blk) * 32'(BLOCK_BYTES);
        k = int'(idx);
        case (ph)
            PH_CMD0_TX:  frame = {CMD0_CODE, 32'h0, CMD0_CRC};
            PH_CMD1_TX:  frame = {CMD1_CODE, 32'h0, IDLE_BYTE};
            PH_CMD16_TX: frame = {CMD16_CODE, 32'(BLOCK_BYTES), IDLE_BYTE};
            PH_RD_TX:    frame = {CMD17_CODE, addr, IDLE_BYTE};
            default:     frame = {CMD24_CODE, addr, IDLE_BYTE};
        endcase
        return frame[47 - 8 * k -: 8];
    endfunction

    function automatic logic [7:0] open_cmd(inout host_state_t s, input phase_t ph);
        s.ph = ph;
        s.bc = 10'd1;
        return frame_byte(ph, 10'd0, s.blk);
    endfunction

    // 1 match, 0 keep polling, -1 out of polls
    function automatic int poll_reply(inout host_state_t s, input logic [7:0] miso,
                                      input logic [7:0] hit_byte);
        if (s.wc != 16'hFFFF)
            s.wc++;
        if (miso == hit_byte)
            return 1;
        if (s.wc >= poll_limit)
            return -1;
        return 0;
    endfunction

    function automatic result_t advance_host(inout host_state_t s, input item_t it);
        result_t    r;
        logic       tx;
        logic       fin;
        logic       want;
        logic       rv;
        logic [7:0] txb;
        logic [1:0] st;
        int         hit;
        r = '0;
        tx = 1'b0;
        fin = 1'b0;
        want = 1'b0;
        rv = 1'b0;
        txb = IDLE_BYTE;
        st = ST_OK;
        hit = 0;
        if (s.ph == PH_IDLE)
        begin
            if (it.op == OP_INIT)
            begin
                s.sel = 1'b1;
                s.retry = 8'd0;
                s.bc = 10'd1;
                s.ph = PH_INIT_CLK;
                tx = 1'b1;
            end
            else if (it.op == OP_READ || it.op == OP_WRITE)
            begin
                s.blk = it.block_number;
                s.sel = 1'b0;
                txb = open_cmd(s, (it.op == OP_READ) ? PH_RD_TX : PH_WR_TX);
                tx = 1'b1;
            end
        end
        else if (it.op == OP_EXCH)
        begin
            tx = 1'b1;
            case (s.ph)
                PH_INIT_CLK:
                begin
                    if (s.bc < wake_bytes)
                        s.bc++;
                    else
                    begin
                        s.sel = 1'b0;
                        txb = open_cmd(s, PH_CMD0_TX);
                    end
                end
                PH_CMD0_TX, PH_CMD1_TX, PH_CMD16_TX, PH_RD_TX, PH_WR_TX:
                begin
                    if (s.bc < CMD_LEN)
                    begin
                        txb = frame_byte(s.ph, s.bc, s.blk);
                        s.bc++;
                    end
                    else
                    begin
                        s.wc = 16'd0;
                        case (s.ph)
                            PH_CMD0_TX:  s.ph = PH_CMD0_WAIT;
                            PH_CMD1_TX:  s.ph = PH_CMD1_WAIT;
                            PH_CMD16_TX: s.ph = PH_CMD16_WAIT;
                            PH_RD_TX:    s.ph = PH_RD_WAIT;
                            default:     s.ph = PH_WR_WAIT;
                        endcase
                    end
                end
                PH_CMD0_WAIT:
                begin
                    hit = poll_reply(s, it.miso_byte, R1_IDLE);
                    if (hit > 0)
                        txb = open_cmd(s, PH_CMD1_TX);
                    else if (hit < 0)
                    begin
                        fin = 1'b1;
                        st = ST_TIMEOUT;
                    end
                end
                PH_CMD1_WAIT:
                begin
                    hit = poll_reply(s, it.miso_byte, R1_READY);
                    // anything but idle or ready fails the attempt at once
                    if (hit == 0 && it.miso_byte != IDLE_BYTE)
                        hit = -1;
                    if (hit > 0)
                    begin
                        s.sel = 1'b1;
                        s.ph = PH_INIT_GAP;
                    end
                    else if (hit < 0)
                    begin
                        if (s.retry != 8'hFF)
                            s.retry++;
                        if (s.retry >= cmd1_tries)
                        begin
                            fin = 1'b1;
                            st = ST_TIMEOUT;
                        end
                        else
                            txb = open_cmd(s, PH_CMD1_TX);
                    end
                end
                PH_INIT_GAP:
                begin
                    s.sel = 1'b0;
                    txb = open_cmd(s, PH_CMD16_TX);
                end
                PH_CMD16_WAIT:
                begin
                    hit = poll_reply(s, it.miso_byte, R1_READY);
                    if (hit != 0)
                    begin
                        fin = 1'b1;
                        st = (hit > 0) ? ST_OK : ST_TIMEOUT;
                    end
                end
                PH_RD_WAIT:
                begin
                    hit = poll_reply(s, it.miso_byte, R1_READY);
                    if (hit > 0)
                    begin
                        s.wc = 16'd0;
                        s.ph = PH_TOK_WAIT;
                    end
                    else if (hit < 0)
                    begin
                        fin = 1'b1;
                        st = ST_TIMEOUT;
                    end
                end
                PH_TOK_WAIT:
                begin
                    hit = poll_reply(s, it.miso_byte, DATA_TOKEN);
                    if (hit > 0)
                    begin
                        s.bc = 10'd0;
                        s.ph = PH_RD_DATA;
                    end
                    else if (hit < 0)
                    begin
                        fin = 1'b1;
                        st = ST_TIMEOUT;
                    end
                end
                PH_RD_DATA:
                begin
                    rv = 1'b1;
                    s.bc++;
                    if (s.bc >= BLOCK_BYTES)
                        s.ph = PH_RD_CRC1;
                end
                PH_RD_CRC1: s.ph = PH_RD_CRC2;
                PH_RD_CRC2:
                begin
                    s.sel = 1'b1;
                    s.ph = PH_RD_TAIL;
                end
                PH_RD_TAIL: fin = 1'b1;
                PH_WR_WAIT:
                begin
                    hit = poll_reply(s, it.miso_byte, R1_READY);
                    if (hit > 0)
                    begin
                        s.bc = 10'd0;
                        s.ph = PH_WR_DATA;
                        want = 1'b1;
                        txb = DATA_TOKEN;
                    end
                    else if (hit < 0)
                    begin
                        fin = 1'b1;
                        st = ST_TIMEOUT;
                    end
                end
                PH_WR_DATA:
                begin
                    txb = it.write_byte;
                    s.bc++;
                    if (s.bc >= BLOCK_BYTES)
                        s.ph = PH_WR_CRC1;
                    else
                        want = 1'b1;
                end
                PH_WR_CRC1: s.ph = PH_WR_CRC2;
                PH_WR_CRC2: s.ph = PH_WR_POLL;
                PH_WR_POLL: s.ph = PH_WR_CHECK;
                PH_WR_CHECK:
                begin
                    fin = 1'b1;
                    st = ((it.miso_byte[3:0] & DRESP_MASK) == DRESP_OK) ? ST_OK : ST_REJECT;
                end
                default: fin = 1'b1;
            endcase
            // every ending releases the card and sends nothing
            if (fin)
            begin
                tx = 1'b0;
                s.sel = 1'b1;
                s.ph = PH_IDLE;
            end
        end
        r.mosi_byte = tx ? txb : 8'h00;
        r.send_byte = tx;
        r.select_n = s.sel;
        r.want_data = want;
        r.read_byte = rv ? it.miso_byte : 8'h00;
        r.read_valid = rv;
        r.busy_res = (s.ph != PH_IDLE);
        r.done_res = fin;
        r.status = fin ? st : ST_OK;
        return r;
    endfunction

    function automatic string res_text(result_t r);
        return $sformatf("mosi=%02h send=%0b sel_n=%0b want=%0b rd=%02h rv=%0b busy=%0b done=%0b st=%0d",
                         r.mosi_byte, r.send_byte, r.select_n, r.want_data, r.read_byte,
                         r.read_valid, r.busy_res, r.done_res, r.status);
    endfunction

    // what the card answers while the host sits in phase ph
    function automatic logic [7:0] card_reply(phase_t ph);
        logic [7:0] hit_byte;
        int         roll;
        case (ph)
            PH_CMD0_WAIT: hit_byte = R1_IDLE;
            PH_CMD1_WAIT, PH_CMD16_WAIT, PH_RD_WAIT, PH_WR_WAIT: hit_byte = R1_READY;
            PH_TOK_WAIT: hit_byte = DATA_TOKEN;
            PH_WR_CHECK:
            begin
                if (reject_wr)
                    return {4'($urandom), 4'hA};
                return ($urandom_range(0, 1) == 0) ? {4'($urandom), DRESP_OK} : 8'($urandom);
            end
            default: return 8'($urandom);
        endcase
        roll = $urandom_range(0, 11);
        if (roll < 3)
            return hit_byte;
        else if (roll < 10)
            return IDLE_BYTE;
        return 8'($urandom);
    endfunction

    task automatic queue_item(input item_t it);
        if (gen_s.ph == PH_IDLE || it.op == OP_EXCH)
            real_items++;
        void'(advance_host(gen_s, it));
        item_backlog.push_back(it);
    endtask

    // one whole sequence, with an occasional ignored start mixed in
    task automatic add_sequence(input logic [1:0] op, input logic [15:0] blk);
        item_t it;
        it.op = op;
        it.block_number = blk;
        it.miso_byte = 8'($urandom);
        it.write_byte = 8'($urandom);
        queue_item(it);
        while (gen_s.ph != PH_IDLE)
        begin
            it.block_number = 16'($urandom);
            it.write_byte = 8'($urandom);
            if ($urandom_range(0, 39) == 0)
            begin
                it.op = 2'($urandom_range(1, 3));
                it.miso_byte = 8'($urandom);
                queue_item(it);
            end
            it.op = OP_EXCH;
            it.miso_byte = card_reply(gen_s.ph);
            queue_item(it);
        end
    endtask

    task automatic settle();
        while (item_backlog.size() != 0 || item_valid || predicted_out.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_regs(input logic [15:0] t, input logic [7:0] r, input logic [7:0] c);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_wdata <= t;
        @(posedge clk);
        cfg_index <= CFG_RETRY;
        cfg_wdata <= {8'($urandom), r};
        @(posedge clk);
        cfg_index <= CFG_CLOCKS;
        cfg_wdata <= {8'($urandom), c};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        poll_limit = t;
        cmd1_tries = r;
        wake_bytes = c;
        @(negedge clk);
    endtask

    task automatic random_phase(input int budget);
        logic [15:0] t;
        logic [7:0]  r;
        logic [7:0]  c;
        int          base;
        int          roll;
        case ($urandom_range(0, 3))
            0: t = 16'($urandom_range(1, 4));
            1: t = 16'($urandom_range(5, 40));
            2: t = 16'($urandom);
            default: t = 16'hFFFF;
        endcase
        case ($urandom_range(0, 3))
            0: r = 8'($urandom_range(1, 3));
            1: r = 8'($urandom_range(4, 20));
            2: r = 8'($urandom);
            default: r = 8'hFF;
        endcase
        case ($urandom_range(0, 2))
            0: c = 8'($urandom_range(1, 4));
            1: c = 8'($urandom_range(5, 30));
            default: c = 8'($urandom);
        endcase
        set_regs(t, r, c);
        base = real_items;
        while (real_items - base < budget)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                add_sequence(OP_EXCH, 16'($urandom));
            else if (roll < 5)
                add_sequence(OP_INIT, 16'($urandom));
            else if (roll < 8)
                add_sequence(OP_READ, 16'($urandom));
            else
                add_sequence(OP_WRITE, 16'($urandom));
        end
        settle();
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // item driver
    always @(posedge clk)
    begin : drive_items
        item_t nxt;
        logic  nv;
        if (rst_n)
        begin
            nv = item_valid;
            nxt = item_in;
            if (item_valid && !item_stall)
            begin
                predicted_out.push_back(advance_host(dut_s, item_in));
                nv = 1'b0;
                if (!quiet && $urandom_range(0, 11) == 0)
                    gap_left = $urandom_range(1, 19);
            end
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (item_backlog.size() != 0)
                begin
                    nxt = item_backlog.pop_front();
                    nv = 1'b1;
                end
            end
            item_valid <= nv;
            item_in <= nxt;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : watch_results
        result_t want_r;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (predicted_out.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer: %s", res_text(result_out));
                end
                else
                begin
                    want_r = predicted_out.pop_front();
                    if (result_out !== want_r)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch expected %s", res_text(want_r));
                            $display("         actual   %s", res_text(result_out));
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 13) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        int base;
        dut_s = HOST_RESET;
        gen_s = HOST_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register reset values, idle exchange, every op, forced write reject
        add_sequence(OP_EXCH, 16'hFFFF);
        add_sequence(OP_INIT, 16'h0000);
        add_sequence(OP_READ, 16'hFFFF);
        reject_wr = 1'b1;
        add_sequence(OP_WRITE, 16'h0000);
        reject_wr = 1'b0;
        add_sequence(OP_WRITE, 16'hA5C3);
        settle();

        // zero registers: one poll, one CMD1 attempt, one clock byte
        set_regs(16'h0000, 8'h00, 8'h00);
        add_sequence(OP_INIT, 16'h0000);
        add_sequence(OP_INIT, 16'h0000);
        add_sequence(OP_READ, 16'h5A5A);
        add_sequence(OP_WRITE, 16'h8001);
        add_sequence(OP_EXCH, 16'h0000);
        settle();

        set_regs(16'h0001, 8'h01, 8'h01);
        add_sequence(OP_INIT, 16'h0000);
        add_sequence(OP_READ, 16'h0001);
        add_sequence(OP_WRITE, 16'h7FFE);
        settle();

        set_regs(16'hFFFF, 8'hFF, 8'hFF);
        add_sequence(OP_INIT, 16'h0000);
        add_sequence(OP_READ, 16'h3C3C);
        add_sequence(OP_WRITE, 16'hC3C3);
        settle();

        base = real_items;
        while (real_items - base < 650)
            random_phase(150);
        quiet = 1'b1;
        random_phase(150);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
